// ===== hw/rtl/tkrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tkrs_pkg
// Shared types and constants of the top-k running sum block: controller
// states, the command and status groups between controller and datapath,
// and the configuration register map.
// ----------------------------------------------------------------------------
package tkrs_pkg;

  localparam int KMaxDefault       = 64;
  localparam int ValueWidthDefault = 32;

  localparam int KEEP_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = KEEP_W;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_LARGEST = 2'd1;

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 7'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic cfg_we;
    logic clear;
    logic insert;
    logic rd_root;
    logic rd_kids;
    logic wr_v;
    logic up_move;
    logic replace;
    logic dn_move;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic room;
    logic empty;
    logic at_top;
    logic up_move;
    logic root_beat;
    logic leaf;
    logic dn_move;
  } stat_t;

endpackage

// ===== hw/rtl/tkrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkrs_ctrl
// Controller state machine: sequences one transaction, a clear or the sift-up
// or root-replace and sift-down walk of the heap datapath.
// ----------------------------------------------------------------------------
module tkrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           valid_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  tkrs_pkg::stat_t stat_i,
  output tkrs_pkg::cmd_t  cmd_o
);
  import tkrs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.op_clear)   state_d = ST_DONE;
        else if (stat_i.room)  state_d = ST_UP_CHK;
        else if (stat_i.empty) state_d = ST_DONE;
        else                   state_d = ST_ROOT_RD;
      end
      ST_UP_CHK: begin
        state_d = stat_i.at_top ? ST_DONE : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_d = stat_i.up_move ? ST_UP_CHK : ST_DONE;
      end
      ST_ROOT_RD: begin
        state_d = ST_ROOT_CMP;
      end
      ST_ROOT_CMP: begin
        state_d = stat_i.root_beat ? ST_DN_CHK : ST_DONE;
      end
      ST_DN_CHK: begin
        state_d = stat_i.leaf ? ST_DONE : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_d = stat_i.dn_move ? ST_DN_CHK : ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy        = (state_q != ST_IDLE);
    valid_o     = (state_q == ST_DONE);
    cfg_ready_o = (state_q == ST_IDLE) && !start;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.latch  = start;
        cmd_o.cfg_we = cfg_valid_i && !start;
      end
      ST_DECIDE: begin
        if (stat_i.op_clear)  cmd_o.clear  = 1'b1;
        else if (stat_i.room) cmd_o.insert = 1'b1;
      end
      ST_UP_CHK: begin
        cmd_o.wr_v = stat_i.at_top;
      end
      ST_UP_CMP: begin
        cmd_o.up_move = stat_i.up_move;
        cmd_o.wr_v    = !stat_i.up_move;
      end
      ST_ROOT_RD: begin
        cmd_o.rd_root = 1'b1;
      end
      ST_ROOT_CMP: begin
        cmd_o.replace = stat_i.root_beat;
      end
      ST_DN_CHK: begin
        cmd_o.wr_v    = stat_i.leaf;
        cmd_o.rd_kids = !stat_i.leaf;
      end
      ST_DN_CMP: begin
        cmd_o.dn_move = stat_i.dn_move;
        cmd_o.wr_v    = !stat_i.dn_move;
      end
      ST_DONE: begin
        cmd_o = '0;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tkrs_dp.sv =====
// ----------------------------------------------------------------------------
// tkrs_dp
// Heap datapath: heap memory with two registered read ports, the moving
// value and index registers, fill count, running sum and the
// configuration registers.
// ----------------------------------------------------------------------------
module tkrs_dp #(
  parameter int K_MAX       = tkrs_pkg::KMaxDefault,
  parameter int VALUE_WIDTH = tkrs_pkg::ValueWidthDefault,
  parameter int AW          = (K_MAX > 1) ? $clog2(K_MAX) : 1,
  parameter int SUM_W       = VALUE_WIDTH + AW
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tkrs_pkg::cmd_t                        cmd_i,
  output tkrs_pkg::stat_t                       stat_o,
  input  logic                                  opcode_i,
  input  logic signed [VALUE_WIDTH-1:0]         value_i,
  input  logic        [tkrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [tkrs_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output logic signed [SUM_W-1:0]               chosen_sum_o
);
  import tkrs_pkg::*;

  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int CW    = AW + 2;
  localparam int LW    = (KEEP_W > CNT_W) ? KEEP_W : CNT_W;

  logic signed [VALUE_WIDTH-1:0] mem [K_MAX];

  logic signed [VALUE_WIDTH-1:0] v_q, rd_a_q, rd_b_q;
  logic                          op_q;
  logic        [AW-1:0]          idx_q;
  logic        [CNT_W-1:0]       held_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic        [KEEP_W-1:0]      keep_count_q;
  logic                          keep_largest_q;

  logic        [AW-1:0]          idx_m1, parent, addr_a, addr_b, child_idx;
  logic        [CW-1:0]          lchild, rchild, held_w;
  logic        [LW-1:0]          keep_ext, kmax_ext, limit, held_ext;
  logic                          r_ok, pick_b, we;
  logic signed [VALUE_WIDTH-1:0] child_val, wr_data;

  function automatic logic nearer(input logic signed [VALUE_WIDTH-1:0] a,
                                  input logic signed [VALUE_WIDTH-1:0] b,
                                  input logic largest);
    return largest ? (a < b) : (a > b);
  endfunction

  always_comb begin
    idx_m1    = idx_q - AW'(1);
    parent    = idx_m1 >> 1;
    lchild    = {1'b0, idx_q, 1'b1};
    rchild    = lchild + CW'(1);
    held_w    = CW'(held_q);
    keep_ext  = LW'(keep_count_q);
    kmax_ext  = LW'(K_MAX);
    limit     = (keep_ext > kmax_ext) ? kmax_ext : keep_ext;
    held_ext  = LW'(held_q);
    addr_a    = cmd_i.rd_root ? '0 : (cmd_i.rd_kids ? lchild[AW-1:0] : parent);
    addr_b    = rchild[AW-1:0];
    r_ok      = (rchild < held_w);
    pick_b    = r_ok && nearer(rd_b_q, rd_a_q, keep_largest_q);
    child_val = pick_b ? rd_b_q : rd_a_q;
    child_idx = pick_b ? rchild[AW-1:0] : lchild[AW-1:0];
    we        = cmd_i.wr_v || cmd_i.up_move || cmd_i.dn_move;
    if (cmd_i.wr_v)         wr_data = v_q;
    else if (cmd_i.up_move) wr_data = rd_a_q;
    else                    wr_data = child_val;
  end

  always_comb begin
    stat_o.op_clear  = op_q;
    stat_o.room      = (held_ext < limit);
    stat_o.empty     = (held_q == '0);
    stat_o.at_top    = (idx_q == '0);
    stat_o.up_move   = nearer(v_q, rd_a_q, keep_largest_q);
    stat_o.root_beat = nearer(rd_a_q, v_q, keep_largest_q);
    stat_o.leaf      = !(lchild < held_w);
    stat_o.dn_move   = nearer(child_val, v_q, keep_largest_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wr_data;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      v_q <= value_i;
    end
    if (cmd_i.insert) begin
      idx_q <= held_q[AW-1:0];
    end else if (cmd_i.up_move) begin
      idx_q <= parent;
    end else if (cmd_i.replace) begin
      idx_q <= '0;
    end else if (cmd_i.dn_move) begin
      idx_q <= child_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q           <= 1'b0;
      held_q         <= '0;
      sum_q          <= '0;
      keep_count_q   <= KEEP_COUNT_RST;
      keep_largest_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        op_q <= opcode_i;
      end
      if (cmd_i.cfg_we) begin
        unique case (cfg_index_i)
          REG_KEEP_COUNT: begin
            keep_count_q <= cfg_data_i[KEEP_W-1:0];
            held_q       <= '0;
            sum_q        <= '0;
          end
          REG_KEEP_LARGEST: begin
            keep_largest_q <= cfg_data_i[0];
            held_q         <= '0;
            sum_q          <= '0;
          end
          default: ;
        endcase
      end else if (cmd_i.clear) begin
        held_q <= '0;
        sum_q  <= '0;
      end else if (cmd_i.insert) begin
        held_q <= held_q + CNT_W'(1);
        sum_q  <= sum_q + SUM_W'(v_q);
      end else if (cmd_i.replace) begin
        sum_q  <= sum_q + SUM_W'(v_q) - SUM_W'(rd_a_q);
      end
    end
  end

  assign chosen_sum_o = sum_q;

endmodule

// ===== hw/rtl/top_k_running_sum.sv =====
// ----------------------------------------------------------------------------
// top_k_running_sum
// Streaming top-k selection: keeps the keep_count (at most K_MAX) smallest
// or largest samples in a binary heap and reports the sum of the kept samples
// after every transaction.
//
// Channel   Direction  Handshake                  Payload
// input     in         start, busy                opcode_i, value_i
// result    out        valid_o (one-cycle strobe) chosen_sum_o
// config    in         cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// A clear, or a push with keep_count zero, goes straight to the result strobe;
// a push that does not beat the root of a full heap is discarded. An insert
// sifts the new sample up a level per compare until it reaches the root or
// stops; a root replace reads the root, compares, then sifts down until it
// reaches a leaf or stops. A new item is accepted only while busy is low.
// Reset empties the heap at once and selects keep_count 1, smallest mode.
// ----------------------------------------------------------------------------
module top_k_running_sum #(
  parameter int K_MAX       = tkrs_pkg::KMaxDefault,
  parameter int VALUE_WIDTH = tkrs_pkg::ValueWidthDefault,
  localparam int AW         = (K_MAX > 1) ? $clog2(K_MAX) : 1,
  localparam int SUM_W      = VALUE_WIDTH + AW
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode_i,
  input  logic signed [VALUE_WIDTH-1:0]         value_i,
  output logic                                  valid_o,
  output logic signed [SUM_W-1:0]               chosen_sum_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [tkrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [tkrs_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import tkrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tkrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .valid_o     (valid_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tkrs_dp #(
    .K_MAX       (K_MAX),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .SUM_W       (SUM_W)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .chosen_sum_o (chosen_sum_o)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy)
    else $error("Controller did not return to idle after the result.");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> (!busy && cmd.cfg_we))
    else $error("Configuration write taken while a transaction is in flight.");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.wr_v, cmd.up_move, cmd.dn_move}))
    else $error("More than one heap write requested in a cycle.");

endmodule
